// ----- hw/rtl/gsf_pkg.sv -----
// Shared constants, types and codes for the goal step follower.
`default_nettype none
package gsf_pkg;

   localparam int POS_WIDTH    = 24;
   localparam int FRAC_BITS    = 12;
   localparam int CORDIC_STEPS = 16;

   localparam int CFG_W   = 16;
   localparam int GAIN_W  = 16;
   localparam int IDX_W   = $clog2(CORDIC_STEPS);
   localparam int DIFF_W  = POS_WIDTH + 1;
   localparam int VEC_W   = POS_WIDTH + 3;
   localparam int STEP_W  = CFG_W + GAIN_W + 3;
   localparam int PROD_W  = VEC_W + GAIN_W + 1;
   localparam int DIST_W  = PROD_W - GAIN_W;
   localparam int RU_W    = STEP_W - GAIN_W;
   localparam int SUM_W   = ((POS_WIDTH > RU_W) ? POS_WIDTH : RU_W) + 1;
   localparam int CSR_IDX_W = 2;

   localparam logic [GAIN_W-1:0] INV_GAIN = GAIN_W'(39797);
   localparam logic [IDX_W-1:0]  LAST_STEP = IDX_W'(CORDIC_STEPS - 1);

   localparam logic [CFG_W-1:0] ARRIVE_RADIUS_RESET =
      CFG_W'(((5 << FRAC_BITS) + 50) / 100);
   localparam logic [CFG_W-1:0] MAX_SPEED_RESET = CFG_W'(1 << (FRAC_BITS - 1));
   localparam logic [CFG_W-1:0] STEP_LENGTH_RESET = ARRIVE_RADIUS_RESET;

   localparam logic [SUM_W-1:0] SAT_HI =
      {{(SUM_W - POS_WIDTH + 1){1'b0}}, {(POS_WIDTH - 1){1'b1}}};
   localparam logic [SUM_W-1:0] SAT_LO =
      {{(SUM_W - POS_WIDTH + 1){1'b1}}, {(POS_WIDTH - 1){1'b0}}};

   localparam logic KIND_GOAL = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ARRIVE_RADIUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_LENGTH   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_PREP,
      ST_ITER,
      ST_SCALE,
      ST_RND,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             load_goal;
      logic             load;
      logic             prep;
      logic             iter;
      logic [IDX_W-1:0] iter_idx;
      logic             scale;
      logic             rnd;
      logic             commit;
   } cmd_type;

   typedef struct packed {
      logic armed;
   } status_type;

endpackage
`default_nettype wire

// ----- hw/rtl/goal_step_follower_top.sv -----
// Top level of the goal step follower: controller, datapath and their connection.
//
//   Channel   Ports              Direction   Moves
//   req       req_valid/ready    in          goal point or control tick request
//   rsp       rsp_valid/ready    out         speed, arrival flag and kept position
//   csr       csr_we             in          write of one of three 16-bit registers
//
// A goal request or a tick while disarmed is taken in the idle state and gives no result.
// An armed tick runs from acceptance through LOAD, PREP, ITER, SCALE, RND and FINISH
// before the next request can be taken; ITER makes the sixteen passes through the one
// shared CORDIC stage. The result register lets the next request be taken while
// a result still waits; a new result waits in the last step until that register is free.
// Reset is synchronous and returns the position to zero and the follower to disarmed.
`default_nettype none
module goal_step_follower_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_kind,
   input  wire logic signed [gsf_pkg::POS_WIDTH-1:0] req_goal_x,
   input  wire logic signed [gsf_pkg::POS_WIDTH-1:0] req_goal_y,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [gsf_pkg::CFG_W-1:0]                 rsp_linear_speed,
   output logic                                      rsp_arrived,
   output logic signed [gsf_pkg::POS_WIDTH-1:0]      rsp_position_x,
   output logic signed [gsf_pkg::POS_WIDTH-1:0]      rsp_position_y,
   input  wire logic                                 csr_we,
   input  wire logic [gsf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [gsf_pkg::CFG_W-1:0]            csr_wdata
);

   gsf_pkg::cmd_type    cmd;
   gsf_pkg::status_type status;

   gsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gsf_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_goal_x       (req_goal_x),
      .req_goal_y       (req_goal_y),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_linear_speed (rsp_linear_speed),
      .rsp_arrived      (rsp_arrived),
      .rsp_position_x   (rsp_position_x),
      .rsp_position_y   (rsp_position_y)
   );

endmodule
`default_nettype wire

// ----- hw/rtl/gsf_ctrl.sv -----
// Controller state machine that sequences one request through the datapath.
`default_nettype none
module gsf_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_kind,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire gsf_pkg::status_type  status,
   output gsf_pkg::cmd_type          cmd
);

   gsf_pkg::state_type state_ff, state_in;
   logic [gsf_pkg::IDX_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gsf_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.iter_idx = cnt_ff;
      unique case (state_ff)
         gsf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == gsf_pkg::KIND_GOAL) begin
                  cmd.load_goal = 1'b1;
               end else if (status.armed) begin
                  state_in = gsf_pkg::ST_LOAD;
               end
            end
         end
         gsf_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = gsf_pkg::ST_PREP;
         end
         gsf_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            cnt_in   = '0;
            state_in = gsf_pkg::ST_ITER;
         end
         gsf_pkg::ST_ITER: begin
            cmd.iter = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == gsf_pkg::LAST_STEP) begin
               state_in = gsf_pkg::ST_SCALE;
            end
         end
         gsf_pkg::ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = gsf_pkg::ST_RND;
         end
         gsf_pkg::ST_RND: begin
            cmd.rnd  = 1'b1;
            state_in = gsf_pkg::ST_FINISH;
         end
         gsf_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = gsf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gsf_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/gsf_datapath.sv -----
// Datapath: goal and position registers, shared CORDIC stage, scaling and result register.
`default_nettype none
module gsf_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire gsf_pkg::cmd_type                     cmd,
   output gsf_pkg::status_type                       status,
   input  wire logic signed [gsf_pkg::POS_WIDTH-1:0] req_goal_x,
   input  wire logic signed [gsf_pkg::POS_WIDTH-1:0] req_goal_y,
   input  wire logic                                 csr_we,
   input  wire logic [gsf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [gsf_pkg::CFG_W-1:0]            csr_wdata,
   output logic [gsf_pkg::CFG_W-1:0]                 rsp_linear_speed,
   output logic                                      rsp_arrived,
   output logic signed [gsf_pkg::POS_WIDTH-1:0]      rsp_position_x,
   output logic signed [gsf_pkg::POS_WIDTH-1:0]      rsp_position_y
);

   localparam int PW = gsf_pkg::POS_WIDTH;
   localparam int DW = gsf_pkg::DIFF_W;
   localparam int VW = gsf_pkg::VEC_W;
   localparam int SW = gsf_pkg::STEP_W;
   localparam int CW = gsf_pkg::CFG_W;
   localparam int GW = gsf_pkg::GAIN_W;
   localparam int QW = gsf_pkg::PROD_W;
   localparam int TW = gsf_pkg::DIST_W;
   localparam int RW = gsf_pkg::RU_W;
   localparam int UW = gsf_pkg::SUM_W;

   logic [CW-1:0] arrive_radius_ff, max_speed_ff, step_length_ff;
   logic signed [PW-1:0] target_x_ff, target_y_ff, here_x_ff, here_y_ff;
   logic signed [PW-1:0] here_x_in, here_y_in;
   logic armed_ff;

   logic signed [DW-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic signed [VW-1:0] x_ff, y_ff, x_in, y_in, dx_ext, dy_ext, x_sh, y_sh;
   logic signed [SW-1:0] u_ff, v_ff, u_in, v_in, u_sh, v_sh, uf_ff, vf_ff;
   logic signed [SW-1:0] u_load;
   logic [2*CW-1:0] step_prod;
   logic flip_ff, pos_dir;
   logic signed [QW-1:0] prod_ff, prod_in, prod_rnd;
   logic signed [TW-1:0] dist_ff;
   logic signed [SW-1:0] u_rnd, v_rnd;
   logic signed [RW-1:0] ru_ff, rv_ff;
   logic signed [UW-1:0] sum_x, sum_y;
   logic signed [TW-1:0] radius_ext, max_ext;
   logic at_goal, below_max;
   logic [CW-1:0] speed;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         arrive_radius_ff <= gsf_pkg::ARRIVE_RADIUS_RESET;
         max_speed_ff     <= gsf_pkg::MAX_SPEED_RESET;
         step_length_ff   <= gsf_pkg::STEP_LENGTH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            gsf_pkg::CSR_ARRIVE_RADIUS: arrive_radius_ff <= csr_wdata;
            gsf_pkg::CSR_MAX_SPEED:     max_speed_ff     <= csr_wdata;
            gsf_pkg::CSR_STEP_LENGTH:   step_length_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Difference to the goal and scaled step length.
   assign dx_in = {target_x_ff[PW-1], target_x_ff} - {here_x_ff[PW-1], here_x_ff};
   assign dy_in = {target_y_ff[PW-1], target_y_ff} - {here_y_ff[PW-1], here_y_ff};
   assign step_prod = step_length_ff * gsf_pkg::INV_GAIN;
   assign u_load = $signed({{(SW - 2*CW){1'b0}}, step_prod});

   assign dx_ext = {{(VW - DW){dx_ff[DW-1]}}, dx_ff};
   assign dy_ext = {{(VW - DW){dy_ff[DW-1]}}, dy_ff};

   // One CORDIC iteration: vectoring on (x, y), matching rotation on (u, v).
   assign pos_dir = ~y_ff[VW-1];
   assign x_sh = x_ff >>> cmd.iter_idx;
   assign y_sh = y_ff >>> cmd.iter_idx;
   assign u_sh = u_ff >>> cmd.iter_idx;
   assign v_sh = v_ff >>> cmd.iter_idx;

   always_comb begin
      if (cmd.prep) begin
         x_in = dx_ff[DW-1] ? -dx_ext : dx_ext;
         y_in = dx_ff[DW-1] ? -dy_ext : dy_ext;
      end else if (pos_dir) begin
         x_in = x_ff + y_sh;
         y_in = y_ff - x_sh;
      end else begin
         x_in = x_ff - y_sh;
         y_in = y_ff + x_sh;
      end
   end

   always_comb begin
      if (cmd.load) begin
         u_in = u_load;
         v_in = '0;
      end else if (pos_dir) begin
         u_in = u_ff - v_sh;
         v_in = v_ff + u_sh;
      end else begin
         u_in = u_ff + v_sh;
         v_in = v_ff - u_sh;
      end
   end

   // Gain correction and rounding.
   assign prod_in  = x_ff * $signed({1'b0, gsf_pkg::INV_GAIN});
   assign prod_rnd = prod_ff + QW'(1 << (GW - 1));
   assign u_rnd    = uf_ff + SW'(1 << (GW - 1));
   assign v_rnd    = vf_ff + SW'(1 << (GW - 1));

   // Position update with saturation and the arrival decision.
   assign sum_x = {{(UW - PW){here_x_ff[PW-1]}}, here_x_ff}
                + {{(UW - RW){ru_ff[RW-1]}}, ru_ff};
   assign sum_y = {{(UW - PW){here_y_ff[PW-1]}}, here_y_ff}
                + {{(UW - RW){rv_ff[RW-1]}}, rv_ff};

   always_comb begin
      if (sum_x > $signed(gsf_pkg::SAT_HI)) begin
         here_x_in = {1'b0, {(PW - 1){1'b1}}};
      end else if (sum_x < $signed(gsf_pkg::SAT_LO)) begin
         here_x_in = {1'b1, {(PW - 1){1'b0}}};
      end else begin
         here_x_in = sum_x[PW-1:0];
      end
      if (sum_y > $signed(gsf_pkg::SAT_HI)) begin
         here_y_in = {1'b0, {(PW - 1){1'b1}}};
      end else if (sum_y < $signed(gsf_pkg::SAT_LO)) begin
         here_y_in = {1'b1, {(PW - 1){1'b0}}};
      end else begin
         here_y_in = sum_y[PW-1:0];
      end
   end

   assign radius_ext = $signed({{(TW - CW){1'b0}}, arrive_radius_ff});
   assign max_ext    = $signed({{(TW - CW){1'b0}}, max_speed_ff});
   assign at_goal    = dist_ff < radius_ext;
   assign below_max  = dist_ff < max_ext;
   assign speed      = below_max ? dist_ff[CW-1:0] : max_speed_ff;

   // Control state kept by the datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff  <= 1'b0;
         here_x_ff <= '0;
         here_y_ff <= '0;
      end else begin
         if (cmd.load_goal) begin
            armed_ff <= 1'b1;
         end else if (cmd.commit && at_goal) begin
            armed_ff <= 1'b0;
         end
         if (cmd.commit && !at_goal) begin
            here_x_ff <= here_x_in;
            here_y_ff <= here_y_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_goal) begin
         target_x_ff <= req_goal_x;
         target_y_ff <= req_goal_y;
      end
      if (cmd.load) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
      if (cmd.prep) begin
         flip_ff <= dx_ff[DW-1];
      end
      if (cmd.prep || cmd.iter) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
      if (cmd.load || cmd.iter) begin
         u_ff <= u_in;
         v_ff <= v_in;
      end
      if (cmd.scale) begin
         prod_ff <= prod_in;
         uf_ff   <= flip_ff ? -u_ff : u_ff;
         vf_ff   <= flip_ff ? -v_ff : v_ff;
      end
      if (cmd.rnd) begin
         dist_ff <= prod_rnd[GW +: TW];
         ru_ff   <= u_rnd[GW +: RW];
         rv_ff   <= v_rnd[GW +: RW];
      end
      if (cmd.commit) begin
         if (at_goal) begin
            rsp_linear_speed <= '0;
            rsp_arrived      <= 1'b1;
            rsp_position_x   <= here_x_ff;
            rsp_position_y   <= here_y_ff;
         end else begin
            rsp_linear_speed <= speed;
            rsp_arrived      <= 1'b0;
            rsp_position_x   <= here_x_in;
            rsp_position_y   <= here_y_in;
         end
      end
   end

   assign status.armed = armed_ff;

endmodule
`default_nettype wire
